// ----- hdl/swm_pkg.sv -----
package swm_pkg;

	// Fixed field widths
	localparam int SEQ_W = 16;   // sample number, wraps modulo 2^16
	localparam int WS_W  = 7;    // window_size register

	// Defaults for the top-level parameters
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FRONT,
		S_BACK,
		S_PUSH
	} swm_state_t;

endpackage

// ----- hdl/swm_ifs.sv -----
// sample channel
interface swm_sample_if import swm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// result channel
interface swm_result_if import swm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	logic                          end_of_sequence;

	modport source (output valid, output window_max, output end_of_sequence, input ready);
	modport sink   (input valid, input window_max, input end_of_sequence, output ready);
endinterface

// window_size write channel
interface swm_cfg_if import swm_pkg::*;;
	logic            valid;
	logic            ready;
	logic [WS_W-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

// ----- hdl/swm_store.sv -----
// candidate store: value and sample number per deque slot, registered read
module swm_store import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] wr_addr,
	input  logic [SAMPLE_BITS+SEQ_W-1:0]                  wr_data,
	input  logic                                          rd_en,
	input  logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] rd_addr,
	output logic [SAMPLE_BITS+SEQ_W-1:0]                  rd_data
);

	localparam int DATA_W = SAMPLE_BITS + SEQ_W;

	logic [DATA_W-1:0] mem [WINDOW_MAX];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/swm_ctrl.sv -----
// deque sequencer: front aging, back pruning, push, result register
module swm_ctrl import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [$clog2(WINDOW_MAX+1)-1:0]               win,
	swm_sample_if.sink                                    samples,
	swm_result_if.source                                  results,
	output logic                                          wr_en,
	output logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] wr_addr,
	output logic [SAMPLE_BITS+SEQ_W-1:0]                  wr_data,
	output logic                                          rd_en,
	output logic [(WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1)-1:0] rd_addr,
	input  logic [SAMPLE_BITS+SEQ_W-1:0]                  rd_data
);

	localparam int IDX_W  = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX+1);
	localparam int DATA_W = SAMPLE_BITS + SEQ_W;

	// (h + off) mod WINDOW_MAX, both operands below WINDOW_MAX
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(WINDOW_MAX)) begin
			s = s - (CNT_W+1)'(WINDOW_MAX);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] h);
		if (h == IDX_W'(WINDOW_MAX-1)) begin
			return '0;
		end
		return h + IDX_W'(1);
	endfunction

	swm_state_t state_q, state_d;

	logic [IDX_W-1:0]              head_q, head_d;
	logic [CNT_W-1:0]              count_q, count_d;
	logic [CNT_W-1:0]              seen_q, seen_d;
	logic [SEQ_W-1:0]              seq_q, seq_d;
	logic signed [SAMPLE_BITS-1:0] val_q, val_d;
	logic                          last_q, last_d;
	logic signed [SAMPLE_BITS-1:0] front_q, front_d;
	logic                          out_valid_q, out_valid_d;
	logic signed [SAMPLE_BITS-1:0] out_max_q, out_max_d;
	logic                          out_eos_q, out_eos_d;

	logic signed [SAMPLE_BITS-1:0] rd_val;
	logic [SEQ_W-1:0]              rd_no;
	logic [SEQ_W-1:0]              age;
	logic                          too_old;
	logic [CNT_W-1:0]              seen_inc, seen_nx;
	logic                          produce;
	logic                          out_free;

	assign rd_val  = rd_data[DATA_W-1:SEQ_W];
	assign rd_no   = rd_data[SEQ_W-1:0];
	assign age     = seq_q - rd_no;
	assign too_old = age >= SEQ_W'(win);

	assign seen_inc = (seen_q < win) ? seen_q + CNT_W'(1) : seen_q;
	assign seen_nx  = (seen_inc > win) ? win : seen_inc;
	assign produce  = seen_nx >= win;
	assign out_free = !out_valid_q || results.ready;

	assign samples.ready           = (state_q == S_IDLE);
	assign results.valid           = out_valid_q;
	assign results.window_max      = out_max_q;
	assign results.end_of_sequence = out_eos_q;

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		seen_d      = seen_q;
		seq_d       = seq_q;
		val_d       = val_q;
		last_d      = last_q;
		front_d     = front_q;
		out_valid_d = out_valid_q && !results.ready;
		out_max_d   = out_max_q;
		out_eos_d   = out_eos_q;
		rd_en       = 1'b0;
		rd_addr     = head_q;
		wr_en       = 1'b0;
		wr_addr     = slot(head_q, count_q);
		wr_data     = {val_q, seq_q};

		unique case (state_q)
			S_IDLE: begin
				if (samples.valid) begin
					val_d   = samples.sample;
					last_d  = samples.last_sample;
					rd_en   = 1'b1;
					state_d = (count_q != '0) ? S_FRONT : S_PUSH;
				end
			end
			S_FRONT: begin
				if (too_old) begin
					head_d  = next_idx(head_q);
					count_d = count_q - CNT_W'(1);
					if (count_q > CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = next_idx(head_q);
					end else begin
						state_d = S_PUSH;
					end
				end else begin
					front_d = rd_val;
					rd_en   = 1'b1;
					rd_addr = slot(head_q, count_q - CNT_W'(1));
					state_d = S_BACK;
				end
			end
			S_BACK: begin
				// equal values are replaced by the newer sample
				if (val_q >= rd_val) begin
					count_d = count_q - CNT_W'(1);
					if (count_q > CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = slot(head_q, count_q - CNT_W'(2));
					end else begin
						state_d = S_PUSH;
					end
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (out_free || !produce) begin
					wr_en   = 1'b1;
					count_d = count_q + CNT_W'(1);
					seq_d   = seq_q + SEQ_W'(1);
					seen_d  = seen_nx;
					if (produce) begin
						out_valid_d = 1'b1;
						out_max_d   = (count_q == '0) ? val_q : front_q;
						out_eos_d   = last_q;
					end
					if (last_q) begin
						head_d  = '0;
						count_d = '0;
						seq_d   = '0;
						seen_d  = '0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			seen_q      <= '0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			seen_q      <= seen_d;
			seq_q       <= seq_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q     <= val_d;
		last_q    <= last_d;
		front_q   <= front_d;
		out_max_q <= out_max_d;
		out_eos_q <= out_eos_d;
	end

endmodule

// ----- hdl/sliding_window_maximum.sv -----
// Sliding window maximum over a stream of signed samples.
// samples : valid/ready beats of {sample, last_sample}.
// results : valid/ready beats of {window_max, end_of_sequence}; one beat per
//           sample once window_size samples of the sequence have arrived.
// cfg     : valid/ready write of window_size, always ready; write it only
//           while the block is idle. 0 acts as 1, above WINDOW_MAX saturates.
// Candidates (value, sample number) live in one synchronous RAM managed as
// a circular monotonic deque. Per sample the sequencer reads the front
// entry once per cycle until it is young enough, then the back entry once
// per cycle while it is not greater than the new sample, then writes it.
// The sequencer examines one deque entry at a time, since the single RAM read
// port serves every front and back read; on an empty deque it goes from idle
// straight to the push. The result beat appears the cycle after the write.
// Reset clears the deque pointers, sample counter and fill count at once;
// the RAM needs no clearing, only live entries are ever used.
// A result waiting in the output register does not block the next sample;
// only the write of a following result waits for the receiver.
// A last_sample beat closes the sequence and empties the deque after it.
module sliding_window_maximum import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	swm_sample_if.sink   samples,
	swm_result_if.source results,
	swm_cfg_if.sink      cfg
);

	localparam int IDX_W  = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX+1);
	localparam int EW_W   = CNT_W > WS_W ? CNT_W : WS_W;
	localparam int DATA_W = SAMPLE_BITS + SEQ_W;

	logic [WS_W-1:0]   win_size_q;
	logic [EW_W-1:0]   ws_ext;
	logic [CNT_W-1:0]  win_eff;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [DATA_W-1:0] rd_data;

	// window_size register, writable any time the sender offers a beat
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q <= WS_RESET;
		end else if (cfg.valid) begin
			win_size_q <= cfg.window_size;
		end
	end

	// effective window: zero means one sample, clamp to store depth
	always_comb begin
		ws_ext = EW_W'(win_size_q);
		if (ws_ext == '0) begin
			win_eff = CNT_W'(1);
		end else if (ws_ext > EW_W'(WINDOW_MAX)) begin
			win_eff = CNT_W'(WINDOW_MAX);
		end else begin
			win_eff = CNT_W'(ws_ext);
		end
	end

	swm_ctrl #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.win     (win_eff),
		.samples (samples),
		.results (results),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	swm_store #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// ----- hdl/swm_checker.sv -----
// port-level checks for sliding_window_maximum
module swm_checker import swm_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] out_max,
	input logic                          out_eos
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_max) && $stable(out_eos))
		else $error("result beat changed while stalled");

	// one sample at a time: never ready straight after a sample beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while previous one in flight");

	// a result needs the push cycle, so it cannot rise right after the beat
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind sliding_window_maximum swm_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_max   (results.window_max),
	.out_eos   (results.end_of_sequence)
);
